>>> hdl/toel_pkg.sv
package toel_pkg;

  localparam int SLOTS       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int ENTRY_W     = 4;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int TIME_W      = 64;
  localparam int CFG_IDX_W   = 1;

  localparam int LIVE_SLOTS  = (SLOTS < (1 << ENTRY_W)) ? SLOTS : (1 << ENTRY_W);
  localparam int CELLS       = LIVE_SLOTS;
  localparam int ADDR_W      = $clog2(LIVE_SLOTS);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_POP    = 3'd2,
    CMD_PEEK   = 3'd3,
    CMD_TICK   = 3'd4,
    CMD_CANCEL = 3'd5
  } command_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NOT_LISTED = 2'd1,
    ST_ALREADY    = 2'd2,
    ST_EMPTY      = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMER_ENABLED = 1'd0,
    CFG_TIMEOUT_SPAN  = 1'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t             op;
    logic [ENTRY_W-1:0]   key;
    logic [TIME_W-1:0]    ex;
  } cell_cmd_t;

  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] span;
    logic              wrap_ok;
  } tick_ctx_t;

  typedef struct packed {
    logic               valid;
    logic [ENTRY_W-1:0] id;
    logic [TIME_W-1:0]  ex;
  } cell_data_t;

endpackage

>>> hdl/toel_ifs.sv
interface toel_in_if import toel_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [ENTRY_W-1:0]  entry_id;
  logic [TIME_W-1:0]   now;

  modport source (output valid, command, entry_id, now, input ready);
  modport sink (input valid, command, entry_id, now, output ready);
endinterface

interface toel_out_if import toel_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ENTRY_W-1:0]  result_entry;
  logic                entry_valid;
  logic                expired;
  logic                timer_active;
  logic                last;

  modport source (output valid, status, result_entry, entry_valid, expired, timer_active,
                  last, input ready);
  modport sink (input valid, status, result_entry, entry_valid, expired, timer_active,
                last, output ready);
endinterface

interface toel_cfg_if import toel_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TIME_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/timed_ordered_entry_list.sv
// Channel  Dir  Payload                                                 Handshake
// in_bus   in   command[2:0] entry_id[3:0] now[63:0]                     valid/ready
// out_bus  out  status[1:0] result_entry[3:0] entry_valid expired
//               timer_active last                                        valid/ready
// cfg_bus  in   index[0:0] data[63:0]                                    valid/ready
//
// One transaction is taken at a time: it is accepted in S_IDLE and executed in S_EXEC,
// which waits until the output register is free to take its result.
// A tick removes each expired entry in S_WALK, one shift of the cell chain each.
// A result waits in the output register; a stalled output holds the executing command.
// Reset is synchronous and active low; it empties the list and stops the timer.

module timed_ordered_entry_list import toel_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  toel_in_if.sink   in_bus,
  toel_out_if.source out_bus,
  toel_cfg_if.sink  cfg_bus
);

  state_t             state_r, state_nxt;
  command_t           cmd_r;
  logic [ENTRY_W-1:0] id_r;
  logic [TIME_W-1:0]  now_r;
  logic               timer_enabled_r;
  logic [TIME_W-1:0]  span_r;
  logic               timer_running_r, timer_running_nxt;
  logic               will_empty_r, will_empty_nxt;
  logic [TIME_W-1:0]  expire_mem [LIVE_SLOTS];
  logic [TIME_W-1:0]  stored_ex_r;

  logic               out_valid_r;
  status_t            out_status_r;
  logic [ENTRY_W-1:0] out_entry_r;
  logic               out_entry_valid_r;
  logic               out_expired_r;
  logic               out_timer_active_r;
  logic               out_last_r;

  status_t            res_status;
  logic [ENTRY_W-1:0] res_entry;
  logic               res_entry_valid;
  logic               res_expired;
  logic               res_timer_active;
  logic               res_last;
  logic               emit;
  logic               out_free;
  logic               mem_we;
  logic               in_range;
  logic [TIME_W-1:0]  add_sum;
  logic [TIME_W-1:0]  add_ex;
  logic [ENTRY_W-1:0] search_key;
  cell_op_t           cell_op;
  cell_cmd_t          cell_cmd;
  tick_ctx_t          tick_ctx;

  cell_data_t         cell_q [CELLS];
  cell_data_t         right_q [CELLS];
  logic               left_valid [CELLS];
  logic [CELLS:0]     kill;
  logic [CELLS:0]     lead;
  logic [CELLS-1:0]   due;
  logic [CELLS-1:0]   valid_vec;

  assign in_bus.ready  = (state_r == S_IDLE);
  assign cfg_bus.ready = 1'b1;
  assign out_free      = !out_valid_r || out_bus.ready;

  assign add_sum    = now_r + span_r;
  assign add_ex     = timer_enabled_r ? add_sum : stored_ex_r;
  assign in_range   = {1'b0, id_r} < (ENTRY_W+1)'(LIVE_SLOTS);
  assign search_key = (state_r == S_WALK || cmd_r == CMD_POP) ? cell_q[0].id : id_r;
  assign cell_cmd   = '{op: cell_op, key: search_key, ex: add_ex};
  assign tick_ctx   = '{now: now_r, span: span_r, wrap_ok: (add_sum > now_r)};

  assign kill[0] = 1'b0;
  assign lead[0] = 1'b1;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign left_valid[k] = 1'b1;
    end else begin : g_inner
      assign left_valid[k] = cell_q[k-1].valid;
    end
    if (k == CELLS - 1) begin : g_end
      assign right_q[k] = '0;
    end else begin : g_mid
      assign right_q[k] = cell_q[k+1];
    end

    toel_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cell_cmd),
      .ctx        (tick_ctx),
      .left_valid (left_valid[k]),
      .from_right (right_q[k]),
      .kill_in    (kill[k]),
      .lead_in    (lead[k]),
      .kill_out   (kill[k+1]),
      .lead_out   (lead[k+1]),
      .due        (due[k]),
      .q          (cell_q[k])
    );

    assign valid_vec[k] = cell_q[k].valid;
  end

  always_comb begin
    state_nxt         = state_r;
    timer_running_nxt = timer_running_r;
    will_empty_nxt    = will_empty_r;
    cell_op           = CELL_HOLD;
    mem_we            = 1'b0;
    emit              = 1'b0;
    res_status        = ST_OK;
    res_entry         = '0;
    res_entry_valid   = 1'b0;
    res_expired       = 1'b0;
    res_last          = 1'b1;
    res_timer_active  = timer_running_r;
    case (state_r)
      S_IDLE: begin
        if (in_bus.valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          case (cmd_r)
            CMD_ADD: begin
              if (!in_range) begin
                res_status = ST_NOT_LISTED;
              end else if (kill[CELLS]) begin
                res_status = ST_ALREADY;
              end else begin
                cell_op = CELL_APPEND;
                mem_we  = timer_enabled_r;
                if (!cell_q[0].valid && timer_enabled_r) begin
                  timer_running_nxt = 1'b1;
                end
              end
            end
            CMD_DELETE: begin
              if (!in_range || !kill[CELLS]) begin
                res_status = ST_NOT_LISTED;
              end else begin
                cell_op = CELL_REMOVE;
              end
            end
            CMD_POP, CMD_PEEK: begin
              if (!cell_q[0].valid) begin
                res_status = ST_EMPTY;
              end else begin
                res_entry       = cell_q[0].id;
                res_entry_valid = 1'b1;
                if (cmd_r == CMD_POP) begin
                  cell_op = CELL_REMOVE;
                end
              end
            end
            CMD_TICK: begin
              if (timer_running_r) begin
                if (due[0]) begin
                  emit           = 1'b0;
                  state_nxt      = S_WALK;
                  will_empty_nxt = lead[CELLS];
                end else begin
                  timer_running_nxt = cell_q[0].valid;
                end
              end
            end
            CMD_CANCEL: begin
              timer_running_nxt = 1'b0;
            end
            default: begin
            end
          endcase
          res_timer_active = timer_running_nxt;
        end
      end
      S_WALK: begin
        if (out_free) begin
          emit             = 1'b1;
          cell_op          = CELL_REMOVE;
          res_entry        = cell_q[0].id;
          res_entry_valid  = 1'b1;
          res_expired      = 1'b1;
          res_last         = !due[1];
          res_timer_active = !will_empty_r;
          if (!due[1]) begin
            timer_running_nxt = !will_empty_r;
            state_nxt         = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      timer_running_r <= 1'b0;
      will_empty_r    <= 1'b0;
      timer_enabled_r <= 1'b0;
      span_r          <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      timer_running_r <= timer_running_nxt;
      will_empty_r    <= will_empty_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_bus.valid) begin
        case (cfg_idx_t'(cfg_bus.index))
          CFG_TIMER_ENABLED: timer_enabled_r <= cfg_bus.data[0];
          CFG_TIMEOUT_SPAN:  span_r          <= cfg_bus.data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      cmd_r       <= command_t'(in_bus.command);
      id_r        <= in_bus.entry_id;
      now_r       <= in_bus.now;
      stored_ex_r <= expire_mem[in_bus.entry_id[ADDR_W-1:0]];
    end
    if (mem_we) begin
      expire_mem[id_r[ADDR_W-1:0]] <= add_sum;
    end
    if (emit) begin
      out_status_r       <= res_status;
      out_entry_r        <= res_entry;
      out_entry_valid_r  <= res_entry_valid;
      out_expired_r      <= res_expired;
      out_timer_active_r <= res_timer_active;
      out_last_r         <= res_last;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.status       = out_status_r;
  assign out_bus.result_entry = out_entry_r;
  assign out_bus.entry_valid  = out_entry_valid_r;
  assign out_bus.expired      = out_expired_r;
  assign out_bus.timer_active = out_timer_active_r;
  assign out_bus.last         = out_last_r;

  // The occupied cells always form an unbroken run starting at the head.
  a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + CELLS'(1))) == '0)
    else $error("occupied cells are not contiguous from the head");

  a_walk_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> cell_q[0].valid && due[0])
    else $error("expiry walk without an expired head entry");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.valid && in_bus.ready |=> state_r == S_EXEC)
    else $error("accepted transaction did not start executing");

  a_expired_named: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_expired_r |-> out_entry_valid_r && out_status_r == ST_OK)
    else $error("expired result without a valid entry");

  a_last_timer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_timer_active_r == timer_running_r)
    else $error("final result disagrees with the timer state");

endmodule

>>> hdl/toel_cell.sv
module toel_cell import toel_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_cmd_t  cmd,
  input  tick_ctx_t  ctx,
  input  logic       left_valid,
  input  cell_data_t from_right,
  input  logic       kill_in,
  input  logic       lead_in,
  output logic       kill_out,
  output logic       lead_out,
  output logic       due,
  output cell_data_t q
);

  logic               valid_r, valid_nxt;
  logic [ENTRY_W-1:0] id_r, id_nxt;
  logic [TIME_W-1:0]  ex_r, ex_nxt;
  logic               match;

  assign match    = valid_r && (id_r == cmd.key);
  assign kill_out = kill_in || match;
  assign due      = valid_r && (ctx.now >= ex_r) && (((ex_r - ctx.span) < ex_r) || ctx.wrap_ok);
  assign lead_out = lead_in && (!valid_r || due);
  assign q        = '{valid: valid_r, id: id_r, ex: ex_r};

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    ex_nxt    = ex_r;
    case (cmd.op)
      CELL_APPEND: begin
        if (!valid_r && left_valid) begin
          valid_nxt = 1'b1;
          id_nxt    = cmd.key;
          ex_nxt    = cmd.ex;
        end
      end
      CELL_REMOVE: begin
        if (kill_out) begin
          valid_nxt = from_right.valid;
          id_nxt    = from_right.id;
          ex_nxt    = from_right.ex;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
    ex_r <= ex_nxt;
  end

endmodule

>>> test/timed_ordered_entry_list_test.sv
module timed_ordered_entry_list_test import toel_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 400000;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [ENTRY_W-1:0] entry_id;
    logic [TIME_W-1:0]  now;
  } request_t;

  typedef struct {
    status_t            status;
    logic [ENTRY_W-1:0] entry;
    logic               entry_valid;
    logic               expired;
    logic               timer_active;
    logic               last;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n;

  toel_in_if  in_bus();
  toel_out_if out_bus();
  toel_cfg_if cfg_bus();

  timed_ordered_entry_list i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus),
    .cfg_bus(cfg_bus)
  );

  always #2 clk = ~clk;

  // Shadow of the entry list, the timer and the two registers.
  logic               listed    [SLOTS];
  logic [ENTRY_W-1:0] fwd_link  [SLOTS];
  logic [ENTRY_W-1:0] back_link [SLOTS];
  logic [TIME_W-1:0]  deadline  [SLOTS];
  logic [ENTRY_W-1:0] head_entry;
  logic [ENTRY_W-1:0] tail_entry;
  logic               list_clear;
  logic               timer_on;
  logic               stamping_on;
  logic [TIME_W-1:0]  span_cfg;

  request_t queued_requests[$];
  outcome_t awaited_results[$];
  request_t offered;
  logic [TIME_W-1:0] time_cursor = '0;
  int in_gap = 0;
  int out_gap = 0;
  int mismatches = 0;
  int cycles = 0;
  bit calm = 1'b0;

  function automatic void push_result(status_t st, logic [ENTRY_W-1:0] e, logic ev,
                                      logic ex, logic lst);
    outcome_t o;
    o.status = st;
    o.entry = e;
    o.entry_valid = ev;
    o.expired = ex;
    o.timer_active = timer_on;
    o.last = lst;
    awaited_results.push_back(o);
  endfunction

  function automatic void detach(logic [ENTRY_W-1:0] e);
    logic [ENTRY_W-1:0] n;
    logic [ENTRY_W-1:0] p;
    n = fwd_link[e];
    p = back_link[e];
    if (head_entry == e && tail_entry == e) begin
      list_clear = 1'b1;
      head_entry = '0;
      tail_entry = '0;
    end else if (head_entry == e) begin
      head_entry = n;
    end else if (tail_entry == e) begin
      tail_entry = p;
    end else begin
      fwd_link[p] = n;
      back_link[n] = p;
    end
    listed[e] = 1'b0;
    fwd_link[e] = '0;
    back_link[e] = '0;
  endfunction

  function automatic void predict_request(request_t r);
    logic [ENTRY_W-1:0] id;
    logic [ENTRY_W-1:0] h;
    logic [TIME_W-1:0] ex;
    logic [TIME_W-1:0] rewound;
    logic [TIME_W-1:0] ahead;
    logic [ENTRY_W-1:0] gone[$];
    id = r.entry_id;
    case (r.command)
      CMD_ADD: begin
        if (listed[id]) begin
          push_result(ST_ALREADY, '0, 1'b0, 1'b0, 1'b1);
        end else begin
          listed[id] = 1'b1;
          fwd_link[id] = '0;
          if (stamping_on) deadline[id] = r.now + span_cfg;
          if (list_clear) begin
            head_entry = id;
            tail_entry = id;
            back_link[id] = '0;
            list_clear = 1'b0;
            if (stamping_on) timer_on = 1'b1;
          end else begin
            fwd_link[tail_entry] = id;
            back_link[id] = tail_entry;
            tail_entry = id;
          end
          push_result(ST_OK, '0, 1'b0, 1'b0, 1'b1);
        end
      end
      CMD_DELETE: begin
        if (!listed[id]) begin
          push_result(ST_NOT_LISTED, '0, 1'b0, 1'b0, 1'b1);
        end else begin
          detach(id);
          push_result(ST_OK, '0, 1'b0, 1'b0, 1'b1);
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (list_clear) begin
          push_result(ST_EMPTY, '0, 1'b0, 1'b0, 1'b1);
        end else begin
          h = head_entry;
          if (r.command == CMD_POP) detach(h);
          push_result(ST_OK, h, 1'b1, 1'b0, 1'b1);
        end
      end
      CMD_TICK: begin
        if (!timer_on) begin
          push_result(ST_OK, '0, 1'b0, 1'b0, 1'b1);
        end else begin
          while (!list_clear && gone.size() < MAX_RESULTS) begin
            h = head_entry;
            ex = deadline[h];
            rewound = ex - span_cfg;
            ahead = r.now + span_cfg;
            if (!(r.now >= ex && (rewound < ex || ahead > r.now))) break;
            detach(h);
            gone.push_back(h);
          end
          timer_on = !list_clear;
          if (gone.size() == 0) begin
            push_result(ST_OK, '0, 1'b0, 1'b0, 1'b1);
          end else begin
            foreach (gone[i]) push_result(ST_OK, gone[i], 1'b1, 1'b1, i == gone.size() - 1);
          end
        end
      end
      CMD_CANCEL: begin
        timer_on = 1'b0;
        push_result(ST_OK, '0, 1'b0, 1'b0, 1'b1);
      end
      default: begin
        push_result(ST_OK, '0, 1'b0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  function automatic void compare_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  function automatic void queue_request(logic [CMD_W-1:0] cmd, logic [ENTRY_W-1:0] id,
                                        logic [TIME_W-1:0] stamp);
    request_t r;
    r.command = cmd;
    r.entry_id = id;
    r.now = stamp;
    queued_requests.push_back(r);
  endfunction

  function automatic void queue_random(logic [TIME_W-1:0] stride);
    int pick;
    logic [CMD_W-1:0] cmd;
    logic [TIME_W-1:0] stamp;
    pick = $urandom_range(0, 99);
    if (pick < 40) cmd = CMD_ADD;
    else if (pick < 55) cmd = CMD_DELETE;
    else if (pick < 63) cmd = CMD_POP;
    else if (pick < 71) cmd = CMD_PEEK;
    else if (pick < 94) cmd = CMD_TICK;
    else if (pick < 97) cmd = CMD_CANCEL;
    else if (pick < 99) cmd = CMD_UNUSED_LO;
    else cmd = CMD_UNUSED_HI;
    case ($urandom_range(0, 19))
      0: stamp = {$urandom, $urandom};
      1: stamp = '1;
      2: stamp = '0;
      default: begin
        time_cursor = time_cursor + ({$urandom, $urandom} % (stride + 64'd1));
        stamp = time_cursor;
      end
    endcase
    queue_request(cmd, ENTRY_W'($urandom_range(0, SLOTS - 1)), stamp);
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (queued_requests.size() > 0 || in_bus.valid || awaited_results.size() > 0);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [TIME_W-1:0] value);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value;
    do @(posedge clk);
    while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (idx == CFG_TIMER_ENABLED) stamping_on = value[0];
    else span_cfg = value;
  endtask

  task automatic run_random(int count, logic [TIME_W-1:0] stride);
    repeat (count) queue_random(stride);
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) predict_request(offered);
      if (!in_bus.valid || in_bus.ready) begin
        if (in_gap == 0 && !calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 9);
        if (in_gap > 0) begin
          in_gap--;
          in_bus.valid <= 1'b0;
        end else if (queued_requests.size() > 0) begin
          offered = queued_requests.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.command <= offered.command;
          in_bus.entry_id <= offered.entry_id;
          in_bus.now <= offered.now;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result with no transaction pending: status %0d, result_entry %0d",
                 out_bus.status, out_bus.result_entry);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("status", 64'(want.status), 64'(out_bus.status));
          compare_field("result_entry", 64'(want.entry), 64'(out_bus.result_entry));
          compare_field("entry_valid", 64'(want.entry_valid), 64'(out_bus.entry_valid));
          compare_field("expired", 64'(want.expired), 64'(out_bus.expired));
          compare_field("timer_active", 64'(want.timer_active), 64'(out_bus.timer_active));
          compare_field("last", 64'(want.last), 64'(out_bus.last));
        end
      end
      if (out_gap == 0 && !calm && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 9);
      if (out_gap > 0) begin
        out_gap--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [TIME_W-1:0] span;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.command = CMD_ADD;
    in_bus.entry_id = '0;
    in_bus.now = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_TIMER_ENABLED;
    cfg_bus.data = '0;
    for (int i = 0; i < SLOTS; i++) begin
      listed[i] = 1'b0;
      fwd_link[i] = '0;
      back_link[i] = '0;
      deadline[i] = '0;
    end
    head_entry = '0;
    tail_entry = '0;
    list_clear = 1'b1;
    timer_on = 1'b0;
    stamping_on = 1'b0;
    span_cfg = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Every slot gets a deadline first, and one tick then expires the whole pool.
    write_register(CFG_TIMER_ENABLED, 64'd1);
    write_register(CFG_TIMEOUT_SPAN, 64'd100);
    for (int i = 0; i < SLOTS; i++) queue_request(CMD_ADD, ENTRY_W'(i), TIME_W'(i));
    queue_request(CMD_TICK, 4'd0, '1);
    queue_request(CMD_ADD, 4'd3, 64'd200);
    queue_request(CMD_ADD, 4'd3, 64'd200);
    queue_request(CMD_DELETE, 4'd9, 64'd200);
    queue_request(CMD_ADD, 4'd5, '0);
    queue_request(CMD_ADD, 4'd7, 64'd210);
    queue_request(CMD_DELETE, 4'd5, 64'd210);
    queue_request(CMD_DELETE, 4'd7, 64'd210);
    queue_request(CMD_POP, 4'd0, 64'd220);
    queue_request(CMD_PEEK, 4'd15, 64'd220);
    queue_request(CMD_CANCEL, 4'd0, 64'd220);
    queue_request(CMD_UNUSED_LO, 4'd10, '1);
    queue_request(CMD_UNUSED_HI, 4'd6, '0);
    wait_drained();

    span = TIME_W'($urandom_range(16, 300));
    write_register(CFG_TIMEOUT_SPAN, span);
    run_random(45, span / 3);

    write_register(CFG_TIMER_ENABLED, 64'd0);
    write_register(CFG_TIMEOUT_SPAN, 64'd0);
    run_random(40, 64'd50);

    write_register(CFG_TIMER_ENABLED, 64'd1);
    write_register(CFG_TIMEOUT_SPAN, '1);
    time_cursor = 64'hFFFF_FFFF_FFFF_FF00;
    run_random(50, 64'd40);

    span = {$urandom_range(1, 15), $urandom};
    write_register(CFG_TIMEOUT_SPAN, span);
    time_cursor = {$urandom, $urandom};
    calm = 1'b1;
    run_random(50, span / 4);

    repeat (20) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
